@@ hdl/pfc_pkg.sv @@
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared types, codes and helpers of the Playfair digraph cipher unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pfc_pkg;

  localparam int unsigned SIDE     = 5;
  localparam int unsigned CELLS    = SIDE * SIDE;
  localparam int unsigned ALPHABET = 26;

  typedef logic [4:0] letter_t;
  typedef logic [4:0] cell_t;
  typedef logic [2:0] coord_t;

  localparam letter_t LETTER_X = 5'd23;
  localparam letter_t LETTER_J = 5'd9;
  localparam letter_t LETTER_I = 5'd8;

  typedef enum logic [2:0] {
    KIND_CLEAR  = 3'd0,
    KIND_KEY    = 3'd1,
    KIND_FINISH = 3'd2,
    KIND_MSG    = 3'd3,
    KIND_END    = 3'd4
  } pfc_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_CELL,
    ST_SQUARE,
    ST_SEND
  } pfc_state_e;

  typedef enum logic [1:0] {
    PAIR_HELD_IN,
    PAIR_IN_X,
    PAIR_HELD_X
  } pfc_pair_sel_e;

  typedef struct packed {
    logic          clear;
    logic          place_key;
    logic          walk_start;
    logic          walk_place;
    logic          hold;
    logic          pair_load;
    pfc_pair_sel_e pair_sel;
    logic          load_out;
  } pfc_cmd_t;

  typedef struct packed {
    logic key_ready;
    logic held_valid;
    logic held_match;
    logic letter_ok;
    logic walk_last;
    logic out_busy;
  } pfc_status_t;

  function automatic coord_t cell_row(cell_t c);
    coord_t r;
    if (c < 5'(SIDE)) begin
      r = 3'd0;
    end else if (c < 5'(2 * SIDE)) begin
      r = 3'd1;
    end else if (c < 5'(3 * SIDE)) begin
      r = 3'd2;
    end else if (c < 5'(4 * SIDE)) begin
      r = 3'd3;
    end else begin
      r = 3'd4;
    end
    return r;
  endfunction

  function automatic coord_t cell_col(cell_t c, coord_t r);
    cell_t base;
    cell_t diff;
    base = 5'(5'(r) * 5'(SIDE));
    diff = c - base;
    return diff[2:0];
  endfunction

  function automatic coord_t step5(coord_t v, logic fwd);
    coord_t s;
    if (fwd) begin
      s = (v == 3'(SIDE - 1)) ? 3'd0 : 3'(v + 3'd1);
    end else begin
      s = (v == 3'd0) ? 3'(SIDE - 1) : 3'(v - 3'd1);
    end
    return s;
  endfunction

  function automatic cell_t to_cell(coord_t r, coord_t c);
    return 5'(5'(r) * 5'(SIDE) + 5'(c));
  endfunction

endpackage

`default_nettype wire

@@ hdl/pfc_datapath.sv @@
// ----------------------------------------------------------------------------
// pfc_datapath
// Square and cell stores, key fill walk, pending letter, pair lookup pipeline
// and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pfc_datapath
  import pfc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire letter_t     in_letter_i,
  input  wire logic        cfg_valid_i,
  input  wire logic        cfg_data_i,
  input  wire pfc_cmd_t    cmd_i,
  output pfc_status_t      status_o,
  input  wire logic        out_ready_i,
  output logic             out_valid_o,
  output letter_t          out_first_o,
  output letter_t          out_second_o
);

  letter_t              square_mem [CELLS];
  cell_t                cell_mem   [ALPHABET];
  logic [ALPHABET-1:0]  placed_q;
  cell_t                fill_q;
  logic                 key_ready_q;
  letter_t              held_q;
  logic                 held_valid_q;
  logic                 direction_q;
  letter_t              walk_q;
  letter_t              a_q, b_q;
  cell_t                ca_q, cb_q;
  letter_t              sqa_q, sqb_q;
  logic                 out_valid_q;
  letter_t              out_first_q, out_second_q;

  letter_t  in_fold;
  letter_t  place_v;
  logic     place_en;
  coord_t   r1, c1, r2, c2;
  cell_t    x_cell, y_cell;

  assign in_fold = (in_letter_i == LETTER_J) ? LETTER_I : in_letter_i;
  assign place_v = cmd_i.place_key ? in_fold : walk_q;

  always_comb begin
    place_en = (cmd_i.place_key || (cmd_i.walk_place && walk_q != LETTER_J))
               && !placed_q[place_v] && (fill_q < 5'(CELLS));
  end

  always_comb begin
    r1 = cell_row(ca_q);
    r2 = cell_row(cb_q);
    c1 = cell_col(ca_q, r1);
    c2 = cell_col(cb_q, r2);
    if (r1 == r2) begin
      x_cell = to_cell(r1, step5(c1, direction_q));
      y_cell = to_cell(r2, step5(c2, direction_q));
    end else if (c1 == c2) begin
      x_cell = to_cell(step5(r1, direction_q), c1);
      y_cell = to_cell(step5(r2, direction_q), c2);
    end else begin
      x_cell = to_cell(r1, c2);
      y_cell = to_cell(r2, c1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (place_en) begin
      cell_mem[place_v] <= fill_q;
      square_mem[fill_q] <= place_v;
    end
    ca_q  <= cell_mem[a_q];
    cb_q  <= cell_mem[b_q];
    sqa_q <= square_mem[x_cell];
    sqb_q <= square_mem[y_cell];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      placed_q     <= '0;
      fill_q       <= '0;
      key_ready_q  <= 1'b0;
      held_valid_q <= 1'b0;
      direction_q  <= 1'b1;
      walk_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        direction_q <= cfg_data_i;
      end
      if (cmd_i.clear) begin
        placed_q     <= '0;
        fill_q       <= '0;
        key_ready_q  <= 1'b0;
        held_valid_q <= 1'b0;
      end
      if (place_en) begin
        placed_q[place_v] <= 1'b1;
        fill_q            <= fill_q + 5'd1;
      end
      if (cmd_i.walk_start) begin
        walk_q <= '0;
      end else if (cmd_i.walk_place) begin
        walk_q <= walk_q + 5'd1;
        if (walk_q == 5'(ALPHABET - 1)) begin
          key_ready_q <= 1'b1;
        end
      end
      if (cmd_i.hold) begin
        held_valid_q <= 1'b1;
      end else if (cmd_i.pair_load && cmd_i.pair_sel != PAIR_IN_X) begin
        held_valid_q <= 1'b0;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.hold) begin
      held_q <= in_fold;
    end
    if (cmd_i.pair_load) begin
      case (cmd_i.pair_sel)
        PAIR_HELD_IN: begin
          a_q <= held_q;
          b_q <= in_fold;
        end
        PAIR_IN_X: begin
          a_q <= in_fold;
          b_q <= LETTER_X;
        end
        PAIR_HELD_X: begin
          a_q <= held_q;
          b_q <= LETTER_X;
        end
        default: begin
          a_q <= held_q;
          b_q <= LETTER_X;
        end
      endcase
    end
    if (cmd_i.load_out) begin
      out_first_q  <= sqa_q;
      out_second_q <= sqb_q;
    end
  end

  always_comb begin
    status_o.key_ready  = key_ready_q;
    status_o.held_valid = held_valid_q;
    status_o.held_match = (held_q == in_fold);
    status_o.letter_ok  = (in_letter_i < 5'(ALPHABET));
    status_o.walk_last  = (walk_q == 5'(ALPHABET - 1));
    status_o.out_busy   = out_valid_q && !out_ready_i;
  end

  assign out_valid_o  = out_valid_q;
  assign out_first_o  = out_first_q;
  assign out_second_o = out_second_q;

endmodule

`default_nettype wire

@@ hdl/pfc_ctrl.sv @@
// ----------------------------------------------------------------------------
// pfc_ctrl
// Controller: decodes input items and sequences key fill and pair lookup.
// ----------------------------------------------------------------------------
`default_nettype none

module pfc_ctrl
  import pfc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  in_kind_i,
  input  wire pfc_status_t status_i,
  output pfc_cmd_t         cmd_o
);

  pfc_state_e state_q, state_d;
  logic       accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.pair_sel = PAIR_HELD_IN;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (pfc_kind_e'(in_kind_i))
            KIND_CLEAR: begin
              cmd_o.clear = 1'b1;
            end
            KIND_KEY: begin
              cmd_o.place_key = !status_i.key_ready && status_i.letter_ok;
            end
            KIND_FINISH: begin
              if (!status_i.key_ready) begin
                cmd_o.walk_start = 1'b1;
                state_d          = ST_FILL;
              end
            end
            KIND_MSG: begin
              if (status_i.key_ready && status_i.letter_ok) begin
                if (!status_i.held_valid) begin
                  cmd_o.hold = 1'b1;
                end else begin
                  cmd_o.pair_load = 1'b1;
                  cmd_o.pair_sel  = status_i.held_match ? PAIR_IN_X : PAIR_HELD_IN;
                  state_d         = ST_CELL;
                end
              end
            end
            KIND_END: begin
              if (status_i.key_ready && status_i.held_valid) begin
                cmd_o.pair_load = 1'b1;
                cmd_o.pair_sel  = PAIR_HELD_X;
                state_d         = ST_CELL;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_FILL: begin
        cmd_o.walk_place = 1'b1;
        if (status_i.walk_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_CELL: begin
        state_d = ST_SQUARE;
      end
      ST_SQUARE: begin
        state_d = ST_SEND;
      end
      ST_SEND: begin
        if (!status_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/playfair_digraph_cipher_unit.sv @@
// ----------------------------------------------------------------------------
// playfair_digraph_cipher_unit
// Playfair cipher over letter codes 0-25 with a 5x5 key square built on chip.
//
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tuser kind, tdata letter
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata first_out, second_out
// cfg       in   cfg_valid_i / cfg_ready_o      cfg_data_i direction
//
// Clear, key letter, held message letter: taken in idle, staying ready for input.
// Pair result: pair load, cell store read, square store read, output load.
// Finish key: the fill walk visits one alphabet letter per cycle.
// Reset clears the placed-letter flags at once; no clearing pass is needed.
// The output register holds a result under stall; the next item is taken
// meanwhile, and a following pair waits for the register to free up.
// ----------------------------------------------------------------------------
`default_nettype none

module playfair_digraph_cipher_unit
  import pfc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [4:0] letter, [7:5] zero
  input  wire logic [2:0]  s_axis_tuser,   // [2:0] kind
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [4:0] first_out, [9:5] second_out, [15:10] zero
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_data_i
);

  pfc_cmd_t    cmd;
  pfc_status_t status;
  letter_t     first_out;
  letter_t     second_out;

  pfc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_kind_i  (s_axis_tuser),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pfc_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_letter_i  (s_axis_tdata[4:0]),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_first_o  (first_out),
    .out_second_o (second_out)
  );

  assign cfg_ready_o  = 1'b1;
  assign m_axis_tdata = {6'd0, second_out, first_out};

endmodule

`default_nettype wire

@@ test/playfair_pair_checker.sv @@
// ----------------------------------------------------------------------------
// playfair_pair_checker
// Watches the letter, pair and direction channels of the Playfair unit. It
// keeps its own key square and pending letter, predicts each enciphered or
// deciphered pair when its letter transfer is seen, and compares every output
// transfer with the oldest predicted pair, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module playfair_pair_checker
  import pfc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,   // [4:0] letter, [7:5] zero
  input  logic [2:0]  s_tuser_i,   // [2:0] kind
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [15:0] m_tdata_i,   // [4:0] first_out, [9:5] second_out, [15:10] zero
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic        cfg_data_i,
  output int          fails_o,
  output int          pending_o
);

  typedef struct packed {
    letter_t second;
    letter_t first;
  } pair_t;

  letter_t square [CELLS];
  cell_t   cell_of [ALPHABET];
  bit      placed [ALPHABET];
  int      filled;
  bit      key_done;
  letter_t held;
  bit      held_ok;
  bit      encrypt;
  pair_t   expected_pairs [$];

  function automatic letter_t fold_j(letter_t v);
    return (v == LETTER_J) ? LETTER_I : v;
  endfunction

  function automatic void place(letter_t v);
    if (placed[v] || filled >= CELLS) return;
    placed[v] = 1'b1;
    cell_of[v] = cell_t'(filled);
    square[filled] = v;
    filled++;
  endfunction

  function automatic pair_t cipher_pair(letter_t a, letter_t b);
    int    r1;
    int    c1;
    int    r2;
    int    c2;
    int    sh;
    int    tmp;
    pair_t p;
    r1 = int'(cell_of[a]) / SIDE;
    c1 = int'(cell_of[a]) % SIDE;
    r2 = int'(cell_of[b]) / SIDE;
    c2 = int'(cell_of[b]) % SIDE;
    sh = encrypt ? 1 : SIDE - 1;
    if (r1 == r2) begin
      c1 = (c1 + sh) % SIDE;
      c2 = (c2 + sh) % SIDE;
    end else if (c1 == c2) begin
      r1 = (r1 + sh) % SIDE;
      r2 = (r2 + sh) % SIDE;
    end else begin
      tmp = c1;
      c1 = c2;
      c2 = tmp;
    end
    p.first = square[r1 * SIDE + c1];
    p.second = square[r2 * SIDE + c2];
    return p;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pair_t   got;
    pair_t   want;
    letter_t raw;
    letter_t v;
    if (!rst_ni) begin
      placed = '{default: 1'b0};
      filled = 0;
      key_done = 1'b0;
      held = '0;
      held_ok = 1'b0;
      encrypt = 1'b1;
      expected_pairs.delete();
      fails_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        encrypt = cfg_data_i;
      end
      if (s_tvalid_i && s_tready_i) begin
        raw = s_tdata_i[4:0];
        v = fold_j(raw);
        case (s_tuser_i)
          KIND_CLEAR: begin
            placed = '{default: 1'b0};
            filled = 0;
            key_done = 1'b0;
            held_ok = 1'b0;
          end
          KIND_KEY: begin
            if (!key_done && raw < ALPHABET) place(v);
          end
          KIND_FINISH: begin
            if (!key_done) begin
              for (int i = 0; i < ALPHABET; i++) begin
                if (letter_t'(i) != LETTER_J) place(letter_t'(i));
              end
              key_done = 1'b1;
            end
          end
          KIND_MSG: begin
            if (key_done && raw < ALPHABET) begin
              if (!held_ok) begin
                held = v;
                held_ok = 1'b1;
              end else if (held == v) begin
                expected_pairs.push_back(cipher_pair(v, LETTER_X));
              end else begin
                expected_pairs.push_back(cipher_pair(held, v));
                held_ok = 1'b0;
              end
            end
          end
          KIND_END: begin
            if (key_done && held_ok) begin
              expected_pairs.push_back(cipher_pair(held, LETTER_X));
              held_ok = 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
      if (m_tvalid_i && m_tready_i) begin
        got = m_tdata_i[9:0];
        if (expected_pairs.size() == 0) begin
          $error("unexpected pair transfer: first_out %0d, second_out %0d",
                 got.first, got.second);
          fails_o++;
        end else begin
          want = expected_pairs.pop_front();
          if (got.first != want.first) begin
            $error("first_out: expected %0d, actual %0d", want.first, got.first);
            fails_o++;
          end
          if (got.second != want.second) begin
            $error("second_out: expected %0d, actual %0d", want.second, got.second);
            fails_o++;
          end
        end
      end
      pending_o = expected_pairs.size();
    end
  end

endmodule

@@ test/tb_playfair_digraph_cipher_unit.sv @@
// ----------------------------------------------------------------------------
// tb_playfair_digraph_cipher_unit
// Drives key and message letter streams into the Playfair unit: a directed
// run over the special cases, then random key sessions in four flow-control
// phases with the cipher direction changed between them. A separate checker
// predicts and compares the pairs; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_playfair_digraph_cipher_unit;
  import pfc_pkg::*;

  localparam logic [2:0] KIND_TOP       = 3'd7;
  localparam int         PHASE_ITEMS    = 370;
  localparam int         HOLD_CYCLES    = 400;
  localparam int         SETTLE_CYCLES  = 40;
  localparam int         WATCHDOG_LIMIT = 3000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [4:0] letter, [7:5] zero
  logic [2:0]  s_axis_tuser = '0;   // [2:0] kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // [4:0] first_out, [9:5] second_out, [15:10] zero
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_data_i = 1'b0;

  int fails;
  int pending;
  int src_idle = 0;
  int sink_stall = 0;
  int items_sent = 0;
  int quiet_cycles = 0;
  bit hold_req = 1'b0;

  playfair_digraph_cipher_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  playfair_pair_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .fails_o     (fails),
    .pending_o   (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hold off the pair channel on request, otherwise stall at random.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("playfair_digraph_cipher_unit verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic letter_t any_letter();
    return letter_t'($urandom());
  endfunction

  task automatic send(logic [2:0] kind, letter_t ltr);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {3'b000, ltr};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_direction(logic dir);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= dir;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_session();
    int      key_len;
    int      msg_len;
    int      r;
    letter_t prev;
    letter_t ltr;
    send(KIND_CLEAR, any_letter());
    if ($urandom_range(3) == 0) send(KIND_MSG, any_letter());
    key_len = ($urandom_range(7) == 0) ? $urandom_range(20, 30) : $urandom_range(0, 10);
    for (int i = 0; i < key_len; i++) begin
      if ($urandom_range(15) == 0) begin
        send(KIND_KEY, letter_t'($urandom_range(ALPHABET, 2 ** $bits(letter_t) - 1)));
      end else begin
        send(KIND_KEY, letter_t'($urandom_range(ALPHABET - 1)));
      end
    end
    send(KIND_FINISH, any_letter());
    if ($urandom_range(3) == 0) send(KIND_FINISH, any_letter());
    if ($urandom_range(3) == 0) send(KIND_KEY, any_letter());
    msg_len = $urandom_range(1, 40);
    prev = letter_t'($urandom_range(ALPHABET - 1));
    for (int i = 0; i < msg_len; i++) begin
      r = $urandom_range(99);
      if (r < 3) begin
        send(3'($urandom_range(KIND_END + 1, KIND_TOP)), any_letter());
      end else if (r < 8) begin
        send(KIND_END, any_letter());
      end else begin
        if (r < 25) ltr = prev;
        else if (r < 35) ltr = LETTER_X;
        else if (r < 40) ltr = LETTER_J;
        else if (r < 43) ltr = letter_t'($urandom_range(ALPHABET, 2 ** $bits(letter_t) - 1));
        else ltr = letter_t'($urandom_range(ALPHABET - 1));
        send(KIND_MSG, ltr);
        prev = ltr;
      end
    end
    if ($urandom_range(3) != 0) send(KIND_END, any_letter());
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, bit hold_off);
    int first;
    src_idle = idle_pct;
    sink_stall = stall_pct;
    if (hold_off) hold_req = 1'b1;
    first = items_sent;
    while (items_sent - first < PHASE_ITEMS) run_session();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_direction(1'b1);

    send(KIND_END, 5'd0);
    send(KIND_MSG, 5'd3);
    send(KIND_KEY, LETTER_J);
    send(KIND_KEY, 5'd31);
    send(KIND_KEY, 5'd0);
    send(KIND_KEY, 5'd25);
    send(KIND_KEY, LETTER_X);
    send(KIND_KEY, 5'd0);
    send(KIND_FINISH, 5'd0);
    send(KIND_FINISH, 5'd31);
    send(KIND_KEY, 5'd4);
    send(KIND_TOP, 5'd31);
    send(KIND_MSG, 5'd0);
    send(KIND_MSG, 5'd0);
    send(KIND_MSG, 5'd25);
    send(KIND_MSG, LETTER_X);
    send(KIND_MSG, LETTER_X);
    send(KIND_END, 5'd0);
    send(KIND_END, 5'd0);
    send(KIND_MSG, LETTER_J);
    send(KIND_MSG, 5'd31);
    send(KIND_MSG, LETTER_I);
    send(KIND_END, 5'd0);
    send(KIND_MSG, 5'd4);
    send(KIND_CLEAR, 5'd0);

    set_direction(1'b0);
    run_phase(0, 0, 1'b1);
    set_direction(1'b1);
    run_phase(83, 0, 1'b0);
    set_direction(1'b0);
    run_phase(0, 83, 1'b0);
    set_direction(1'b1);
    run_phase(11, 11, 1'b0);
    drain();

    if (fails == 0 && pending == 0) begin
      $display("playfair_digraph_cipher_unit verification clean");
    end else begin
      $display("playfair_digraph_cipher_unit verification failed");
    end
    $finish;
  end

endmodule
